[design/uvfp_pkg.sv]
// Shared types and constants for the velocity frame parser.
package uvfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam int FRAME_LEN  = 40;
   localparam int FRAME_BITS = 8 * FRAME_LEN;
   localparam int POS_W      = 6;

   // frame position codes
   localparam logic [POS_W-1:0] POS_HUNT       = 6'd0;
   localparam logic [POS_W-1:0] POS_SYNC2      = 6'd1;
   localparam logic [POS_W-1:0] POS_FIRST_DATA = 6'd2;
   localparam logic [POS_W-1:0] POS_CK_A       = 6'd42;
   localparam logic [POS_W-1:0] POS_CK_B       = 6'd43;

   // word kinds passed from front to back
   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_EMIT  = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
   } word_type;

   typedef struct packed {
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic [31:0] time_of_week;
      logic [31:0] vel_north;
      logic [31:0] vel_east;
      logic [31:0] vel_down;
      logic [31:0] speed_3d;
      logic [31:0] ground_speed;
      logic [31:0] heading_value;
      logic [31:0] speed_accuracy;
      logic [31:0] heading_accuracy;
   } result_type;

endpackage

[design/uvfp_front.sv]
// Front end: sync hunt, frame position and running Fletcher checksum.
module uvfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            rx_byte,
   output logic                  word_valid,
   output uvfp_pkg::word_type    word
);

   logic [uvfp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 sum_a_ff, sum_a_in;
   logic [7:0]                 sum_b_ff, sum_b_in;
   logic [7:0]                 sum_a_next;

   assign sum_a_next = sum_a_ff + rx_byte;

   always_comb begin
      pos_in     = pos_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      word_valid = 1'b0;
      word.kind  = uvfp_pkg::KIND_STORE;
      word.data  = rx_byte;
      if (take) begin
         priority if (pos_ff == uvfp_pkg::POS_HUNT) begin
            pos_in = (rx_byte == uvfp_pkg::SYNC_FIRST) ? uvfp_pkg::POS_SYNC2
                                                       : uvfp_pkg::POS_HUNT;
         end else if (pos_ff == uvfp_pkg::POS_SYNC2) begin
            if (rx_byte == uvfp_pkg::SYNC_SECOND) begin
               pos_in   = uvfp_pkg::POS_FIRST_DATA;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else begin
               pos_in = uvfp_pkg::POS_HUNT;
            end
         end else if (pos_ff < uvfp_pkg::POS_CK_A) begin
            word_valid = 1'b1;
            sum_a_in   = sum_a_next;
            sum_b_in   = sum_b_ff + sum_a_next;
            pos_in     = pos_ff + 6'd1;
         end else if (pos_ff == uvfp_pkg::POS_CK_A) begin
            pos_in = (rx_byte == sum_a_ff) ? uvfp_pkg::POS_CK_B : uvfp_pkg::POS_HUNT;
         end else if (pos_ff == uvfp_pkg::POS_CK_B) begin
            pos_in = uvfp_pkg::POS_HUNT;
            if (rx_byte == sum_b_ff) begin
               word_valid = 1'b1;
               word.kind  = uvfp_pkg::KIND_EMIT;
            end
         end else begin
            pos_in = uvfp_pkg::POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= uvfp_pkg::POS_HUNT;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
      end else begin
         pos_ff   <= pos_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

endmodule

[design/uvfp_fifo.sv]
// Short word queue between front and back.
module uvfp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  uvfp_pkg::word_type    push_word,
   output logic                  full,
   input  logic                  pop_take,
   output uvfp_pkg::word_type    pop_word,
   output logic                  empty
);

   uvfp_pkg::word_type            mem_ff [uvfp_pkg::QUEUE_DEPTH];
   logic [uvfp_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [uvfp_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [uvfp_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign full     = (count_ff == uvfp_pkg::QCNT_W'(uvfp_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop_take && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/uvfp_back.sv]
// Back end: frame byte shift register, field unpacking and result register.
module uvfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  uvfp_pkg::word_type    q_word,
   output logic                  q_take,
   input  logic                  rsp_take,
   output logic                  rsp_valid,
   output uvfp_pkg::result_type  rsp_data
);

   // bytes shift in from the top; after a full body, frame byte k sits at [8k+7:8k]
   logic [uvfp_pkg::FRAME_BITS-1:0] frame_ff;
   uvfp_pkg::result_type            result_ff, result_in;
   logic                            valid_ff, valid_in;
   logic                            slot_free;

   assign slot_free = !valid_ff || rsp_take;
   assign q_take    = !q_empty && ((q_word.kind == uvfp_pkg::KIND_STORE) || slot_free);

   // little-endian fields fall out as plain slices of the shifted body
   always_comb begin
      result_in.msg_class        = frame_ff[7:0];
      result_in.msg_id           = frame_ff[15:8];
      result_in.payload_len      = frame_ff[31:16];
      result_in.time_of_week     = frame_ff[63:32];
      result_in.vel_north        = frame_ff[95:64];
      result_in.vel_east         = frame_ff[127:96];
      result_in.vel_down         = frame_ff[159:128];
      result_in.speed_3d         = frame_ff[191:160];
      result_in.ground_speed     = frame_ff[223:192];
      result_in.heading_value    = frame_ff[255:224];
      result_in.speed_accuracy   = frame_ff[287:256];
      result_in.heading_accuracy = frame_ff[319:288];
   end

   always_comb begin
      valid_in = valid_ff;
      if (q_take && (q_word.kind == uvfp_pkg::KIND_EMIT)) begin
         valid_in = 1'b1;
      end else if (rsp_take) begin
         valid_in = 1'b0;
      end
   end

   // frame bytes and result payload need no reset
   always_ff @(posedge clock) begin
      if (q_take && (q_word.kind == uvfp_pkg::KIND_STORE)) begin
         frame_ff <= {q_word.data, frame_ff[uvfp_pkg::FRAME_BITS-1:8]};
      end
      if (q_take && (q_word.kind == uvfp_pkg::KIND_EMIT)) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = result_ff;

endmodule

[design/ubx_velocity_frame_parser_unit.sv]
// Top level of the velocity frame parser: front, word queue, back.
//
//  channel   ports                       word                    accepted when
//  --------  --------------------------  ----------------------  -------------------
//  request   push, full, req_rx_byte      one received byte       push && !full
//  response  empty, pop, rsp_*            one unpacked frame      pop && !empty
//
// One byte is taken per cycle; the front end decides position and checksum in
// the same cycle, so push is taken every cycle unless the four-word queue is full.
// After the last checksum byte is accepted, its frame-done word enters the queue
// and is then taken by the back end, which loads the result register; empty falls then.
// Reset (synchronous, active high) returns the hunt to the first sync byte and
// empties the queue and the result register; the frame store is not cleared.
// A waiting result stalls only the frame-done word, so bytes keep flowing
// until the queue fills, and full then holds off push.
module ubx_velocity_frame_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [7:0]          req_rx_byte,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_msg_class,
   output logic [7:0]          rsp_msg_id,
   output logic [15:0]         rsp_payload_len,
   output logic [31:0]         rsp_time_of_week,
   output logic signed [31:0]  rsp_vel_north,
   output logic signed [31:0]  rsp_vel_east,
   output logic signed [31:0]  rsp_vel_down,
   output logic [31:0]         rsp_speed_3d,
   output logic [31:0]         rsp_ground_speed,
   output logic signed [31:0]  rsp_heading_value,
   output logic [31:0]         rsp_speed_accuracy,
   output logic [31:0]         rsp_heading_accuracy
);

   logic                  take;
   logic                  word_valid;
   uvfp_pkg::word_type    front_word;
   logic                  q_empty;
   logic                  q_take;
   uvfp_pkg::word_type    q_word;
   logic                  rsp_valid;
   uvfp_pkg::result_type  rsp_data;

   // input word accepted
   assign take = push && !full;

   uvfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_rx_byte),
      .word_valid (word_valid),
      .word       (front_word)
   );

   uvfp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (word_valid),
      .push_word  (front_word),
      .full       (full),
      .pop_take   (q_take),
      .pop_word   (q_word),
      .empty      (q_empty)
   );

   uvfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_word    (q_word),
      .q_take    (q_take),
      .rsp_take  (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign empty                = !rsp_valid;
   assign rsp_msg_class        = rsp_data.msg_class;
   assign rsp_msg_id           = rsp_data.msg_id;
   assign rsp_payload_len      = rsp_data.payload_len;
   assign rsp_time_of_week     = rsp_data.time_of_week;
   assign rsp_vel_north        = $signed(rsp_data.vel_north);
   assign rsp_vel_east         = $signed(rsp_data.vel_east);
   assign rsp_vel_down         = $signed(rsp_data.vel_down);
   assign rsp_speed_3d         = rsp_data.speed_3d;
   assign rsp_ground_speed     = rsp_data.ground_speed;
   assign rsp_heading_value    = $signed(rsp_data.heading_value);
   assign rsp_speed_accuracy   = rsp_data.speed_accuracy;
   assign rsp_heading_accuracy = rsp_data.heading_accuracy;

endmodule
